// ===== rtl/bda_pkg.sv =====
`default_nettype none
package bda_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int MAX_DIGITS  = 20;
  localparam int BCD_WIDTH   = 4 * MAX_DIGITS;
  localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
  localparam int IDX_WIDTH   = $clog2(MAX_DIGITS);
  localparam int CHAR_WIDTH  = 6;

  localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = CHAR_WIDTH'(48);
  localparam logic [3:0]            ADJ_LIMIT  = 4'd5;
  localparam logic [3:0]            ADJ_ADD    = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic advance;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic steps_done;
    logic top_zero;
    logic idx_last;
    logic ovf;
    logic out_free;
  } dp_status_t;

  function automatic logic [BCD_WIDTH-1:0] bcd_adjust(input logic [BCD_WIDTH-1:0] bcd);
    logic [BCD_WIDTH-1:0] res;
    logic [3:0]           dig;
    res = bcd;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      dig = bcd[4*i +: 4];
      if (dig >= ADJ_LIMIT) begin
        res[4*i +: 4] = dig + ADJ_ADD;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bda_ctrl.sv =====
`default_nettype none
module bda_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire bda_pkg::dp_status_t status_i,
  output bda_pkg::ctrl_cmd_t       cmd_o
);
  import bda_pkg::*;

  state_e state_q, state_d;
  logic   leading_q, leading_d;

  always_comb begin
    state_d     = state_q;
    leading_d   = leading_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          leading_d  = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        if (status_i.steps_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // skip leading zeros unless the value wrapped
        if (leading_q && status_i.top_zero && !status_i.idx_last && !status_i.ovf) begin
          cmd_o.advance = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.advance = 1'b1;
          cmd_o.emit    = 1'b1;
          leading_d     = 1'b0;
          if (status_i.idx_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      leading_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      leading_q <= leading_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bda_datapath.sv =====
`default_nettype none
module bda_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [bda_pkg::VALUE_WIDTH-1:0]     value_i,
  input  wire bda_pkg::ctrl_cmd_t                  cmd_i,
  output bda_pkg::dp_status_t                      status_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [bda_pkg::CHAR_WIDTH-1:0]           out_char_o,
  output logic                                     out_last_o
);
  import bda_pkg::*;

  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [BCD_WIDTH-1:0]   bcd_q, bcd_d, bcd_adj;
  logic                   ovf_q, ovf_d;
  logic [STEP_WIDTH-1:0]  step_q, step_d;
  logic [IDX_WIDTH-1:0]   idx_q, idx_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_WIDTH-1:0]  out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;
  logic [3:0]             top_digit;

  assign bcd_adj   = bcd_adjust(bcd_q);
  assign top_digit = bcd_q[BCD_WIDTH-1 -: 4];

  assign status_o.steps_done = (step_q == '0);
  assign status_o.top_zero   = (top_digit == 4'd0);
  assign status_o.idx_last   = (idx_q == '0);
  assign status_o.ovf        = ovf_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    ovf_d       = ovf_q;
    step_d      = step_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (cmd_i.load) begin
      bin_d  = value_i;
      bcd_d  = '0;
      ovf_d  = 1'b0;
      step_d = STEP_WIDTH'(VALUE_WIDTH - 1);
      idx_d  = IDX_WIDTH'(MAX_DIGITS - 1);
    end
    if (cmd_i.step) begin
      // add-3 then shift, top bit lost means the value wrapped
      bcd_d  = {bcd_adj[BCD_WIDTH-2:0], bin_q[VALUE_WIDTH-1]};
      ovf_d  = ovf_q | bcd_adj[BCD_WIDTH-1];
      bin_d  = {bin_q[VALUE_WIDTH-2:0], 1'b0};
      step_d = step_q - 1'b1;
    end
    if (cmd_i.advance) begin
      bcd_d = {bcd_q[BCD_WIDTH-5:0], 4'd0};
      idx_d = idx_q - 1'b1;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_char_d  = ASCII_ZERO + {{(CHAR_WIDTH-4){1'b0}}, top_digit};
      out_last_d  = (idx_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      idx_q       <= idx_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter.
// The slave stream takes one unsigned 64-bit value per item on s_axis_tdata.
// The master stream gives its decimal digits as ASCII characters, most
// significant first, one item per digit, leading zeros dropped; zero gives a
// single '0'. m_axis_tlast marks the least significant digit.
// After an item is accepted, a shift-and-add-3 converter shifts in all 64
// bits, one bit per cycle. A digit scan then walks all 20 digit positions, one
// per cycle, skipping leading zeros and loading each digit into the output
// register. s_axis_tready is high only between items, so a new value is
// accepted only after the digit scan of the previous value has finished.
// A stall on m_axis_tready holds the output register and pauses the digit
// scan; the last character may wait while the next value is accepted.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the block to waiting for an input item.
`default_nettype none
module binary_to_decimal_ascii (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // number_in[63:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // digit_char[5:0], zero [7:6]
  output logic             m_axis_tlast    // last_digit
);
  import bda_pkg::*;

  ctrl_cmd_t             cmd;
  dp_status_t            status;
  logic [CHAR_WIDTH-1:0] out_char;

  bda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bda_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (s_axis_tdata[VALUE_WIDTH-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(8-CHAR_WIDTH){1'b0}}, out_char};

endmodule
`default_nettype wire

// ===== sim/binary_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps
module binary_to_decimal_ascii_tb;
  import bda_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PERCENT = 29;
  localparam int SETTLE_CYCLES = 120;
  localparam int CORNER_COUNT = 19;

  localparam logic [63:0] CORNER_VALUES [0:CORNER_COUNT-1] = '{
    64'd0,
    64'd1,
    64'd9,
    64'd10,
    64'd99,
    64'd100,
    64'd101,
    64'd1000000007,
    64'h0000_0000_FFFF_FFFF,
    64'h0000_0001_0000_0000,
    64'h8000_0000_0000_0000,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'd1234567890123456789,
    64'd9999999999999999999,
    64'd10000000000000000000,
    64'd10000000000000000001,
    64'd18446744073709551614,
    64'hFFFF_FFFF_FFFF_FFFF
  };

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] digit;
    logic                  last;
  } digit_item_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [63:0] s_tdata  = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  digit_item_t digits_due[$];
  int          error_count   = 0;
  int          cycle_count   = 0;
  bit          idle_on       = 1'b1;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;

  binary_to_decimal_ascii u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void predict_digits(input logic [VALUE_WIDTH-1:0] value);
    logic [3:0]             bcd [MAX_DIGITS];
    logic [VALUE_WIDTH-1:0] rest;
    int                     count;
    digit_item_t            entry;
    rest  = value;
    count = 0;
    do begin
      bcd[count] = 4'(rest % 10);
      rest       = rest / 10;
      count++;
    end while (rest != 0 && count < MAX_DIGITS);
    for (int k = count - 1; k >= 0; k--) begin
      entry.digit = ASCII_ZERO + CHAR_WIDTH'(bcd[k]);
      entry.last  = (k == 0);
      digits_due.push_back(entry);
    end
  endfunction

  function automatic logic [63:0] random_number();
    logic [63:0] value;
    int          bits;
    int          pick;
    pick  = $urandom_range(9);
    value = {$urandom, $urandom};
    if (pick >= 4 && pick <= 7) begin
      bits = $urandom_range(64, 1);
      if (bits < 64) begin
        value &= (64'd1 << bits) - 64'd1;
      end
    end else if (pick == 8) begin
      value = 64'd1;
      repeat ($urandom_range(19)) value *= 64'd10;
      if ($urandom_range(1) == 1) begin
        value -= 64'd1;
      end
    end else if (pick == 9) begin
      value = ($urandom_range(1) == 1) ? '1 : '0;
    end
    return value;
  endfunction

  // checker: compare each accepted digit with the oldest expectation
  always @(posedge clk_i) begin : check_digits
    digit_item_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (digits_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected item, expected none, actual tdata %h tlast %b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = digits_due.pop_front();
        if (m_tdata !== {2'b00, want.digit} || m_tlast !== want.last) begin
          error_count++;
          $display("%0t: mismatch, expected tdata %h tlast %b, actual tdata %h tlast %b",
                   $time, {2'b00, want.digit}, want.last, m_tdata, m_tlast);
        end
      end
    end
  end

  // receiver ready, with random idling and long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  task automatic send_number(input logic [63:0] value);
    while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk_i); while (!s_tready);
    predict_digits(value[VALUE_WIDTH-1:0]);
  endtask

  task automatic wait_all_digits();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (digits_due.size() != 0);
  endtask

  task automatic test_corner_values();
    for (int i = 0; i < CORNER_COUNT; i++) begin
      send_number(CORNER_VALUES[i]);
    end
    wait_all_digits();
  endtask

  task automatic test_output_stall();
    hold_requests++;
    repeat (6) send_number(random_number());
    wait_all_digits();
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    repeat (60) send_number(random_number());
    wait_all_digits();
    idle_on = 1'b1;
  endtask

  task automatic test_random_numbers();
    repeat (175) send_number(random_number());
    wait_all_digits();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_corner_values();
    test_output_stall();
    test_no_idle();
    test_random_numbers();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && digits_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
